// ===== rtl/core/e2r_pkg.sv =====
// Shared constants, types and the arctangent table of the Euler-to-rotation-matrix block.
package e2r_pkg;

   // Output format and pipeline shape.
   localparam int OUT_FRAC_BITS_DEF = 14;
   localparam int CORDIC_STEPS      = 20;
   localparam int MATRIX_STAGES     = 5;
   localparam int PIPE_DEPTH        = 1 + CORDIC_STEPS + MATRIX_STAGES;

   // Field and datapath widths.
   localparam int ANG_W = 16;
   localparam int OUT_W = 16;
   localparam int XY_W  = 33;
   localparam int Z_W   = 28;
   localparam int Q_W   = 32;
   localparam int P_W   = 64;

   // Angles in degrees with 6 fraction bits.
   localparam logic signed [ANG_W:0] DEG360 = 17'sd23040;
   localparam logic signed [ANG_W:0] DEG180 = 17'sd11520;
   localparam logic signed [ANG_W:0] DEG90  = 17'sd5760;

   // CORDIC gain and unity in Q30.
   localparam logic signed [XY_W-1:0] CORDIC_K_Q30 = 33'sd652032874;
   localparam logic signed [XY_W-1:0] ONE_Q30      = 33'sd1073741824;

   // State of one rotator lane.
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   neg_cos;
   } rot_type;

   // atan(2^-i) in degrees with 16 fraction bits.
   function automatic logic signed [Z_W-1:0] atan_deg(input int step);
      logic signed [Z_W-1:0] r;
      case (step)
         0:       r = 28'sd2949120;
         1:       r = 28'sd1740967;
         2:       r = 28'sd919879;
         3:       r = 28'sd466945;
         4:       r = 28'sd234379;
         5:       r = 28'sd117304;
         6:       r = 28'sd58666;
         7:       r = 28'sd29335;
         8:       r = 28'sd14668;
         9:       r = 28'sd7334;
         10:      r = 28'sd3667;
         11:      r = 28'sd1833;
         12:      r = 28'sd917;
         13:      r = 28'sd458;
         14:      r = 28'sd229;
         15:      r = 28'sd115;
         16:      r = 28'sd57;
         17:      r = 28'sd29;
         18:      r = 28'sd14;
         19:      r = 28'sd7;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/e2r_if.sv =====
// Handshake interfaces for the angle words and the matrix words.
interface e2r_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [e2r_pkg::ANG_W-1:0]      yaw_angle;
   logic signed [e2r_pkg::ANG_W-1:0]      pitch_angle;
   logic signed [e2r_pkg::ANG_W-1:0]      roll_angle;
   modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
   modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface e2r_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [e2r_pkg::OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

// ===== rtl/core/e2r_reduce.sv =====
// Angle reduction into [-90, 90] degrees and CORDIC start values for one lane.
module e2r_reduce (
   input  logic                             clock,
   input  logic                             ld,
   input  logic signed [e2r_pkg::ANG_W-1:0] angle,
   output e2r_pkg::rot_type                 rot
);

   logic signed [e2r_pkg::ANG_W:0] a_wrap;
   logic signed [e2r_pkg::ANG_W:0] a_fold;
   logic                           neg_cos;
   e2r_pkg::rot_type               rot_in;
   e2r_pkg::rot_type               rot_ff;

   // Wrap into [-180, 180) and fold into [-90, 90], flipping cosine on a fold.
   always_comb begin
      a_wrap = (e2r_pkg::ANG_W+1)'(angle);
      if (a_wrap >= e2r_pkg::DEG180) begin
         a_wrap = a_wrap - e2r_pkg::DEG360;
      end else if (a_wrap < -e2r_pkg::DEG180) begin
         a_wrap = a_wrap + e2r_pkg::DEG360;
      end
      a_fold  = a_wrap;
      neg_cos = 1'b0;
      if (a_wrap > e2r_pkg::DEG90) begin
         a_fold  = e2r_pkg::DEG180 - a_wrap;
         neg_cos = 1'b1;
      end else if (a_wrap < -e2r_pkg::DEG90) begin
         a_fold  = -e2r_pkg::DEG180 - a_wrap;
         neg_cos = 1'b1;
      end
      rot_in.x       = e2r_pkg::CORDIC_K_Q30;
      rot_in.y       = '0;
      rot_in.z       = {{(e2r_pkg::Z_W-e2r_pkg::ANG_W-11){a_fold[e2r_pkg::ANG_W]}},
                        a_fold, 10'b0};
      rot_in.neg_cos = neg_cos;
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         rot_ff <= rot_in;
      end
   end

   assign rot = rot_ff;

endmodule

// ===== rtl/core/e2r_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation of one lane, registered.
module e2r_cell #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  logic             ld,
   input  e2r_pkg::rot_type rot_i,
   output e2r_pkg::rot_type rot_o
);

   logic signed [e2r_pkg::XY_W-1:0] dx;
   logic signed [e2r_pkg::XY_W-1:0] dy;
   e2r_pkg::rot_type                rot_in;
   e2r_pkg::rot_type                rot_ff;

   // Rotate toward zero residual angle using the old x and y.
   always_comb begin
      dx     = rot_i.x >>> STEP;
      dy     = rot_i.y >>> STEP;
      rot_in = rot_i;
      if (!rot_i.z[e2r_pkg::Z_W-1]) begin
         rot_in.x = rot_i.x - dy;
         rot_in.y = rot_i.y + dx;
         rot_in.z = rot_i.z - e2r_pkg::atan_deg(STEP);
      end else begin
         rot_in.x = rot_i.x + dy;
         rot_in.y = rot_i.y - dx;
         rot_in.z = rot_i.z + e2r_pkg::atan_deg(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         rot_ff <= rot_in;
      end
   end

   assign rot_o = rot_ff;

endmodule

// ===== rtl/core/e2r_matrix.sv =====
// Product pipeline: clamps sine and cosine, forms the nine elements, rounds and saturates.
module e2r_matrix #(
   parameter int OUT_FRAC_BITS = e2r_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic [e2r_pkg::MATRIX_STAGES-1:0]     ld,
   input  e2r_pkg::rot_type                      rot [3],
   output logic signed [e2r_pkg::OUT_W-1:0]      mat [9]
);

   localparam int SH = 60 - OUT_FRAC_BITS;
   localparam logic signed [e2r_pkg::P_W-1:0] RND = 64'sd1 <<< (SH - 1);
   localparam logic signed [e2r_pkg::P_W-1:0] LIM = 64'sd1 <<< OUT_FRAC_BITS;
   localparam logic signed [e2r_pkg::P_W-1:0] HALF_Q30 = 64'sd1 <<< 29;

   // Lane 0 is yaw, lane 1 pitch, lane 2 roll.
   logic signed [e2r_pkg::Q_W-1:0] s_in [3], c_in [3];
   logic signed [e2r_pkg::Q_W-1:0] s_ff [3], c_ff [3];
   logic signed [e2r_pkg::Q_W-1:0] s1_ff [3], c1_ff [3];
   logic signed [e2r_pkg::XY_W-1:0] xc, yc;
   logic signed [e2r_pkg::P_W-1:0] cysp_p, sysp_p;
   logic signed [e2r_pkg::Q_W-1:0] cysp_ff, sysp_ff;
   logic signed [e2r_pkg::P_W-1:0] p_in [13], p_ff [13];
   logic signed [e2r_pkg::P_W-1:0] q_in [9], q_ff [9];
   logic signed [e2r_pkg::P_W-1:0] r_val [9];
   logic signed [e2r_pkg::OUT_W-1:0] o_in [9], o_ff [9];

   // Clamp to unity and apply the cosine sign from the fold.
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         xc = rot[l].x;
         yc = rot[l].y;
         if (xc > e2r_pkg::ONE_Q30) xc = e2r_pkg::ONE_Q30;
         if (xc < -e2r_pkg::ONE_Q30) xc = -e2r_pkg::ONE_Q30;
         if (yc > e2r_pkg::ONE_Q30) yc = e2r_pkg::ONE_Q30;
         if (yc < -e2r_pkg::ONE_Q30) yc = -e2r_pkg::ONE_Q30;
         s_in[l] = yc[e2r_pkg::Q_W-1:0];
         c_in[l] = rot[l].neg_cos ? -xc[e2r_pkg::Q_W-1:0] : xc[e2r_pkg::Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         s_ff <= s_in;
         c_ff <= c_in;
      end
   end

   // Shared partial products cy*sp and sy*sp, rounded back to Q30.
   assign cysp_p = (c_ff[0] * s_ff[1] + HALF_Q30) >>> 30;
   assign sysp_p = (s_ff[0] * s_ff[1] + HALF_Q30) >>> 30;

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         cysp_ff <= cysp_p[e2r_pkg::Q_W-1:0];
         sysp_ff <= sysp_p[e2r_pkg::Q_W-1:0];
         s1_ff   <= s_ff;
         c1_ff   <= c_ff;
      end
   end

   // All Q60 products.
   always_comb begin
      p_in[0]  = c1_ff[0] * c1_ff[1];
      p_in[1]  = cysp_ff  * s1_ff[2];
      p_in[2]  = s1_ff[0] * c1_ff[2];
      p_in[3]  = cysp_ff  * c1_ff[2];
      p_in[4]  = s1_ff[0] * s1_ff[2];
      p_in[5]  = s1_ff[0] * c1_ff[1];
      p_in[6]  = sysp_ff  * s1_ff[2];
      p_in[7]  = c1_ff[0] * c1_ff[2];
      p_in[8]  = sysp_ff  * c1_ff[2];
      p_in[9]  = c1_ff[0] * s1_ff[2];
      p_in[10] = -(e2r_pkg::P_W'(s1_ff[1]) <<< 30);
      p_in[11] = c1_ff[1] * s1_ff[2];
      p_in[12] = c1_ff[1] * c1_ff[2];
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         p_ff <= p_in;
      end
   end

   // Element sums.
   always_comb begin
      q_in[0] = p_ff[0];
      q_in[1] = p_ff[1] - p_ff[2];
      q_in[2] = p_ff[3] + p_ff[4];
      q_in[3] = p_ff[5];
      q_in[4] = p_ff[6] + p_ff[7];
      q_in[5] = p_ff[8] - p_ff[9];
      q_in[6] = p_ff[10];
      q_in[7] = p_ff[11];
      q_in[8] = p_ff[12];
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         q_ff <= q_in;
      end
   end

   // Round half up to the output format, then saturate to plus or minus one.
   always_comb begin
      for (int e = 0; e < 9; e++) begin
         r_val[e] = (q_ff[e] + RND) >>> SH;
         if (r_val[e] > LIM) r_val[e] = LIM;
         if (r_val[e] < -LIM) r_val[e] = -LIM;
         o_in[e] = r_val[e][e2r_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         o_ff <= o_in;
      end
   end

   assign mat = o_ff;

endmodule

// ===== rtl/core/euler_to_rotation_matrix.sv =====
// Top level: Euler ZYX angles to rotation matrix, a row of CORDIC cells and a product pipeline.
// An accepted angle word passes a reduction stage, 20 CORDIC cells and 5 product and rounding
// stages to become its matrix word. Throughput: one word per cycle without result stalls;
// each CORDIC cell and product stage is a register stage.
// Stages whose word is empty accept even while the result register is stalled.
// Reset clears all stage valid flags; the datapath registers are not reset.
module euler_to_rotation_matrix #(
   parameter int OUT_FRAC_BITS = e2r_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   e2r_req_if.sink   req_ch,
   e2r_rsp_if.source rsp_ch
);

   localparam int D  = e2r_pkg::PIPE_DEPTH;
   localparam int NC = e2r_pkg::CORDIC_STEPS;

   logic [D-1:0]     v_ff, v_in, ld;
   e2r_pkg::rot_type rot [3][NC+1];
   e2r_pkg::rot_type rot_end [3];
   logic signed [e2r_pkg::ANG_W-1:0] ang [3];
   logic signed [e2r_pkg::OUT_W-1:0] mat [9];

   // Stage load enables: a stage takes a word when it is empty or its word moves on.
   genvar k;
   generate
      for (k = 0; k < D; k++) begin : g_ctl
         if (k == D - 1) begin : g_last
            assign ld[k]   = !v_ff[k] || rsp_ch.ready;
            assign v_in[k] = ld[k] ? v_ff[k-1] : v_ff[k];
         end else if (k == 0) begin : g_first
            assign ld[k]   = !v_ff[k] || ld[k+1];
            assign v_in[k] = ld[k] ? req_ch.valid : v_ff[k];
         end else begin : g_mid
            assign ld[k]   = !v_ff[k] || ld[k+1];
            assign v_in[k] = ld[k] ? v_ff[k-1] : v_ff[k];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ch.ready = ld[0];
   assign ang[0] = req_ch.yaw_angle;
   assign ang[1] = req_ch.pitch_angle;
   assign ang[2] = req_ch.roll_angle;

   // Three lanes of reduction followed by a row of CORDIC cells.
   genvar l, c;
   generate
      for (l = 0; l < 3; l++) begin : g_lane
         e2r_reduce u_reduce (
            .clock (clock),
            .ld    (ld[0]),
            .angle (ang[l]),
            .rot   (rot[l][0])
         );
         for (c = 0; c < NC; c++) begin : g_cell
            e2r_cell #(.STEP(c)) u_cell (
               .clock (clock),
               .ld    (ld[c+1]),
               .rot_i (rot[l][c]),
               .rot_o (rot[l][c+1])
            );
         end
         assign rot_end[l] = rot[l][NC];
      end
   endgenerate

   e2r_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_matrix (
      .clock (clock),
      .ld    (ld[D-1:NC+1]),
      .rot   (rot_end),
      .mat   (mat)
   );

   assign rsp_ch.valid = v_ff[D-1];
   assign rsp_ch.m00 = mat[0];
   assign rsp_ch.m01 = mat[1];
   assign rsp_ch.m02 = mat[2];
   assign rsp_ch.m10 = mat[3];
   assign rsp_ch.m11 = mat[4];
   assign rsp_ch.m12 = mat[5];
   assign rsp_ch.m20 = mat[6];
   assign rsp_ch.m21 = mat[7];
   assign rsp_ch.m22 = mat[8];

endmodule

// ===== rtl/core/e2r_checker.sv =====
// Port-level checker for the Euler-to-rotation-matrix block, bound to the top level.
module e2r_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [e2r_pkg::OUT_W-1:0] rsp_m20
);

   localparam int CW = $clog2(e2r_pkg::PIPE_DEPTH + 1);

   logic [CW-1:0] cnt_ff, cnt_in;

   // Words accepted but not yet delivered.
   always_comb begin
      cnt_in = cnt_ff;
      if (req_valid && req_ready) cnt_in = cnt_in + 1'b1;
      if (rsp_valid && rsp_ready) cnt_in = cnt_in - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("result word without an accepted angle word");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(e2r_pkg::PIPE_DEPTH))
      else $error("more words in flight than pipeline stages");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the result register is empty");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_m20))
      else $error("stalled result word changed");

endmodule

bind euler_to_rotation_matrix e2r_checker u_e2r_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_m20   (rsp_ch.m20)
);
